// ----- src/pinhole_project_with_jacobian_core_defines.svh -----
// assertion macros shared by the checker
`ifndef PINHOLE_PROJECT_WITH_JACOBIAN_CORE_DEFINES_SVH
`define PINHOLE_PROJECT_WITH_JACOBIAN_CORE_DEFINES_SVH

// checked only outside reset
`define PJC_ASSERT_RST(label, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pjc assertion failed");

// checked at every edge, reset included
`define PJC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) else $error("pjc assertion failed");

`endif

// ----- src/pjc_pkg.sv -----
package pjc_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    // widest dividend: (qu << FRAC_BITS), qu at most 2^(2*WORD_BITS-1)
    localparam int NUM_W     = 2 * WORD_BITS + FRAC_BITS;
    localparam int LANES     = 5;
    localparam int CFG_IDX_W = 3;

    // lane slots of the divider rows
    localparam int LN_U  = 0;
    localparam int LN_V  = 1;
    localparam int LN_FX = 2;
    localparam int LN_SX = 3;
    localparam int LN_FY = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X  = 3'd0,
        REG_FOCAL_Y  = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_SKEW     = 3'd4
    } cfg_reg_t;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [NUM_W-1:0]     num_t;
    typedef logic signed [NUM_W+1:0] wide_s_t;

    // one division lane: remainder plus dividend bits shifting out, quotient bits in
    typedef struct packed {
        word_t rem;
        num_t  nq;
    } lane_t;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             want;
        logic             zneg;
        word_t            zm;
        logic [LANES-1:0] neg;
        word_t            u;
        word_t            v;
        word_t            jx;
        word_t            jsx;
        word_t            jy;
        logic             sat;
    } side_t;

    typedef struct packed {
        side_t                 side;
        lane_t [LANES-1:0]     lane;
    } stage_t;

    typedef struct packed {
        word_t val;
        logic  sat;
    } clip_t;

    typedef struct packed {
        word_t pixel_u;
        word_t pixel_v;
        word_t du_by_dx;
        word_t du_by_dy;
        word_t du_by_dz;
        word_t dv_by_dy;
        word_t dv_by_dz;
        logic  depth_zero;
        logic  saturated;
    } res_t;

    // magnitude of a two's complement word (most negative maps to 2^(WORD_BITS-1))
    function automatic word_t mag_of(word_t raw);
        return raw[WORD_BITS-1] ? (~raw + 1'b1) : raw;
    endfunction

    // round half away from zero from the final remainder
    function automatic num_t round_q(lane_t l, word_t d);
        word_t half_gap;
        half_gap = d - l.rem;
        return l.nq + num_t'(l.rem >= half_gap);
    endfunction

    // sign and magnitude to a saturated word
    function automatic clip_t clip_mag(logic neg, num_t m);
        num_t  lim;
        num_t  mag;
        clip_t c;
        lim = '0;
        lim[WORD_BITS-1] = 1'b1;
        if (!neg) lim = lim - 1'b1;
        mag   = m;
        c.sat = 1'b0;
        if (m > lim) begin
            mag   = lim;
            c.sat = 1'b1;
        end
        c.val = neg ? (~mag[WORD_BITS-1:0] + 1'b1) : mag[WORD_BITS-1:0];
        return c;
    endfunction

    function automatic wide_s_t to_wide(logic neg, num_t m);
        wide_s_t ext;
        ext = wide_s_t'({2'b00, m});
        return neg ? -ext : ext;
    endfunction

    // signed wide value to a saturated word
    function automatic clip_t clip_signed(wide_s_t s);
        wide_s_t hi_lim;
        wide_s_t lo_lim;
        clip_t   c;
        hi_lim = '0;
        hi_lim[WORD_BITS-2:0] = '1;
        lo_lim = ~hi_lim;
        c.sat = 1'b0;
        c.val = s[WORD_BITS-1:0];
        if (s > hi_lim) begin
            c.val = hi_lim[WORD_BITS-1:0];
            c.sat = 1'b1;
        end else if (s < lo_lim) begin
            c.val = lo_lim[WORD_BITS-1:0];
            c.sat = 1'b1;
        end
        return c;
    endfunction

endpackage

// ----- src/pjc_if.sv -----
// point channel
interface pjc_point_if;
    import pjc_pkg::*;
    logic  valid;
    logic  ready;
    word_t point_x;
    word_t point_y;
    word_t point_z;
    logic  want_jacobian;
    modport source (output valid, point_x, point_y, point_z, want_jacobian, input ready);
    modport sink   (input valid, point_x, point_y, point_z, want_jacobian, output ready);
endinterface

// result channel
interface pjc_result_if;
    import pjc_pkg::*;
    logic  valid;
    logic  ready;
    word_t pixel_u;
    word_t pixel_v;
    word_t du_by_dx;
    word_t du_by_dy;
    word_t du_by_dz;
    word_t dv_by_dy;
    word_t dv_by_dz;
    logic  depth_zero;
    logic  saturated;
    modport source (output valid, pixel_u, pixel_v, du_by_dx, du_by_dy, du_by_dz,
                    dv_by_dy, dv_by_dz, depth_zero, saturated, input ready);
    modport sink   (input valid, pixel_u, pixel_v, du_by_dx, du_by_dy, du_by_dz,
                    dv_by_dy, dv_by_dz, depth_zero, saturated, output ready);
endinterface

// configuration write channel
interface pjc_cfg_if;
    import pjc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    word_t                data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/pjc_div_cell.sv -----
module pjc_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  pjc_pkg::stage_t d_in,
    output pjc_pkg::stage_t d_out
);
    import pjc_pkg::*;

    stage_t             stage_reg;
    stage_t             stage_next;
    logic               valid_reg;
    logic [WORD_BITS:0] rs   [LANES];
    logic [WORD_BITS:0] diff [LANES];
    logic [LANES-1:0]   ge;

    // one restoring step per lane, all lanes share the divisor
    always_comb
    begin
        stage_next = d_in;
        for (int k = 0; k < LANES; k++)
        begin
            rs[k]   = {d_in.lane[k].rem, d_in.lane[k].nq[NUM_W-1]};
            diff[k] = rs[k] - {1'b0, d_in.side.zm};
            ge[k]   = rs[k] >= {1'b0, d_in.side.zm};
            stage_next.lane[k].rem = ge[k] ? diff[k][WORD_BITS-1:0] : rs[k][WORD_BITS-1:0];
            stage_next.lane[k].nq  = {d_in.lane[k].nq[NUM_W-2:0], ge[k]};
        end
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= d_in.side.valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
            stage_reg <= stage_next;
    end

    always_comb
    begin
        d_out = stage_reg;
        d_out.side.valid = valid_reg;
    end

endmodule

// ----- src/pinhole_project_with_jacobian_core.sv -----
// pinhole projection with point jacobian, one point per cycle sustained
// stages in order: products, dividends, first divider row, rounding, u and v, second divider row,
// rounding, output; the divider rows are one-bit cells, the second divides the rounded u and v
// throughput: one transaction per cycle; the whole pipeline holds only when the result waits
// reset: registers return to fx = fy = 1.0, cx = cy = skew = 0, all valid bits cleared
module pinhole_project_with_jacobian_core (
    input  logic         clk,
    input  logic         rst_n,
    pjc_cfg_if.sink      cfg,
    pjc_point_if.sink    pt,
    pjc_result_if.source res
);
    import pjc_pkg::*;

    word_t focal_x_reg, focal_y_reg, center_x_reg, center_y_reg, skew_reg;
    logic  adv;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= word_t'(1 << FRAC_BITS);
            focal_y_reg  <= word_t'(1 << FRAC_BITS);
            center_x_reg <= '0;
            center_y_reg <= '0;
            skew_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_FOCAL_X:  focal_x_reg  <= cfg.data;
                REG_FOCAL_Y:  focal_y_reg  <= cfg.data;
                REG_CENTER_X: center_x_reg <= cfg.data;
                REG_CENTER_Y: center_y_reg <= cfg.data;
                REG_SKEW:     skew_reg     <= cfg.data;
                default: ;
            endcase
        end
    end

    logic out_valid_reg;
    res_t out_reg;

    // every stage moves together unless the result is held
    assign adv      = !out_valid_reg || res.ready;
    assign pt.ready = adv;

    // stage 1: magnitude products
    logic [2*WORD_BITS-1:0] prod_u1_reg, prod_u2_reg, prod_v_reg;
    logic [2*WORD_BITS-1:0] prod_u1_next, prod_u2_next, prod_v_next;
    logic s1_valid_reg, sg_u1_reg, sg_u2_reg, sg_v_reg, zneg_reg, zero_reg, want_reg;
    logic [2:0] sg_j_reg;
    word_t zm_reg;

    assign prod_u1_next = mag_of(focal_x_reg) * mag_of(pt.point_x);
    assign prod_u2_next = mag_of(skew_reg) * mag_of(pt.point_y);
    assign prod_v_next  = mag_of(focal_y_reg) * mag_of(pt.point_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= pt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_u1_reg <= prod_u1_next;
            prod_u2_reg <= prod_u2_next;
            prod_v_reg  <= prod_v_next;
            sg_u1_reg   <= focal_x_reg[WORD_BITS-1] ^ pt.point_x[WORD_BITS-1];
            sg_u2_reg   <= skew_reg[WORD_BITS-1] ^ pt.point_y[WORD_BITS-1];
            sg_v_reg    <= focal_y_reg[WORD_BITS-1] ^ pt.point_y[WORD_BITS-1];
            sg_j_reg    <= {focal_y_reg[WORD_BITS-1], skew_reg[WORD_BITS-1],
                            focal_x_reg[WORD_BITS-1]} ^ {3{pt.point_z[WORD_BITS-1]}};
            zneg_reg    <= pt.point_z[WORD_BITS-1];
            zm_reg      <= mag_of(pt.point_z);
            zero_reg    <= pt.point_z == '0;
            want_reg    <= pt.want_jacobian;
        end
    end

    // stage 2: numerator of u and the dividends of all first-row lanes
    stage_t  s2_reg, s2_next, s2_out;
    logic    s2_valid_reg;
    wide_s_t nu_s, nu_a;

    always_comb
    begin
        nu_s = to_wide(sg_u1_reg, num_t'(prod_u1_reg)) + to_wide(sg_u2_reg, num_t'(prod_u2_reg));
        nu_a = nu_s[NUM_W+1] ? -nu_s : nu_s;
        s2_next = '0;
        s2_next.side.zero = zero_reg;
        s2_next.side.want = want_reg;
        s2_next.side.zneg = zneg_reg;
        s2_next.side.zm   = zm_reg;
        s2_next.side.neg[LN_U]  = nu_s[NUM_W+1];
        s2_next.side.neg[LN_V]  = sg_v_reg;
        s2_next.side.neg[LN_FX] = sg_j_reg[0];
        s2_next.side.neg[LN_SX] = sg_j_reg[1];
        s2_next.side.neg[LN_FY] = sg_j_reg[2];
        s2_next.lane[LN_U].nq  = nu_a[NUM_W-1:0];
        s2_next.lane[LN_V].nq  = num_t'(prod_v_reg);
        s2_next.lane[LN_FX].nq = num_t'(mag_of(focal_x_reg)) << FRAC_BITS;
        s2_next.lane[LN_SX].nq = num_t'(mag_of(skew_reg)) << FRAC_BITS;
        s2_next.lane[LN_FY].nq = num_t'(mag_of(focal_y_reg)) << FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_reg <= s2_next;
    end

    always_comb
    begin
        s2_out = s2_reg;
        s2_out.side.valid = s2_valid_reg;
    end

    // first divider row
    stage_t link1 [NUM_W+1];
    assign link1[0] = s2_out;

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_row1
        pjc_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .d_in  (link1[i]),
            .d_out (link1[i+1])
        );
    end

    // round first-row quotients
    stage_t r1_reg, r1_next;
    logic   r1_valid_reg;

    always_comb
    begin
        r1_next = link1[NUM_W];
        for (int k = 0; k < LANES; k++)
            r1_next.lane[k].nq = round_q(link1[NUM_W].lane[k], link1[NUM_W].side.zm);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r1_valid_reg <= 1'b0;
        else if (adv)
            r1_valid_reg <= link1[NUM_W].side.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            r1_reg <= r1_next;
    end

    // u, v and the constant jacobian terms; dividends of the depth terms
    stage_t p2_reg, p2_next, p2_out;
    logic   p2_valid_reg;
    clip_t  cu, cv, cjx, cjs, cjy;

    always_comb
    begin
        cu  = clip_signed(to_wide(r1_reg.side.neg[LN_U], r1_reg.lane[LN_U].nq)
                          + wide_s_t'(signed'(center_x_reg)));
        cv  = clip_signed(to_wide(r1_reg.side.neg[LN_V], r1_reg.lane[LN_V].nq)
                          + wide_s_t'(signed'(center_y_reg)));
        cjx = clip_mag(r1_reg.side.neg[LN_FX], r1_reg.lane[LN_FX].nq);
        cjs = clip_mag(r1_reg.side.neg[LN_SX], r1_reg.lane[LN_SX].nq);
        cjy = clip_mag(r1_reg.side.neg[LN_FY], r1_reg.lane[LN_FY].nq);
        p2_next = '0;
        p2_next.side.zero = r1_reg.side.zero;
        p2_next.side.want = r1_reg.side.want;
        p2_next.side.zneg = r1_reg.side.zneg;
        p2_next.side.zm   = r1_reg.side.zm;
        p2_next.side.neg[LN_U] = !r1_reg.side.neg[LN_U] ^ r1_reg.side.zneg;
        p2_next.side.neg[LN_V] = !r1_reg.side.neg[LN_V] ^ r1_reg.side.zneg;
        p2_next.side.u   = cu.val;
        p2_next.side.v   = cv.val;
        p2_next.side.jx  = cjx.val;
        p2_next.side.jsx = cjs.val;
        p2_next.side.jy  = cjy.val;
        p2_next.side.sat = cu.sat | cv.sat
                         | (r1_reg.side.want & (cjx.sat | cjs.sat | cjy.sat));
        p2_next.lane[LN_U].nq = r1_reg.lane[LN_U].nq << FRAC_BITS;
        p2_next.lane[LN_V].nq = r1_reg.lane[LN_V].nq << FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (adv)
            p2_valid_reg <= r1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            p2_reg <= p2_next;
    end

    always_comb
    begin
        p2_out = p2_reg;
        p2_out.side.valid = p2_valid_reg;
    end

    // second divider row
    stage_t link2 [NUM_W+1];
    assign link2[0] = p2_out;

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_row2
        pjc_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .d_in  (link2[i]),
            .d_out (link2[i+1])
        );
    end

    // round depth-term quotients
    stage_t r2_reg, r2_next;
    logic   r2_valid_reg;

    always_comb
    begin
        r2_next = link2[NUM_W];
        for (int k = 0; k < LANES; k++)
            r2_next.lane[k].nq = round_q(link2[NUM_W].lane[k], link2[NUM_W].side.zm);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r2_valid_reg <= 1'b0;
        else if (adv)
            r2_valid_reg <= link2[NUM_W].side.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            r2_reg <= r2_next;
    end

    // final assembly with zero-depth and no-jacobian cases
    res_t  out_next;
    clip_t cdu, cdv;

    always_comb
    begin
        cdu = clip_mag(r2_reg.side.neg[LN_U], r2_reg.lane[LN_U].nq);
        cdv = clip_mag(r2_reg.side.neg[LN_V], r2_reg.lane[LN_V].nq);
        out_next = '0;
        if (r2_reg.side.zero)
            out_next.depth_zero = 1'b1;
        else
        begin
            out_next.pixel_u   = r2_reg.side.u;
            out_next.pixel_v   = r2_reg.side.v;
            out_next.saturated = r2_reg.side.sat
                               | (r2_reg.side.want & (cdu.sat | cdv.sat));
            if (r2_reg.side.want)
            begin
                out_next.du_by_dx = r2_reg.side.jx;
                out_next.du_by_dy = r2_reg.side.jsx;
                out_next.du_by_dz = cdu.val;
                out_next.dv_by_dy = r2_reg.side.jy;
                out_next.dv_by_dz = cdv.val;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= r2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign res.valid      = out_valid_reg;
    assign res.pixel_u    = out_reg.pixel_u;
    assign res.pixel_v    = out_reg.pixel_v;
    assign res.du_by_dx   = out_reg.du_by_dx;
    assign res.du_by_dy   = out_reg.du_by_dy;
    assign res.du_by_dz   = out_reg.du_by_dz;
    assign res.dv_by_dy   = out_reg.dv_by_dy;
    assign res.dv_by_dz   = out_reg.dv_by_dz;
    assign res.depth_zero = out_reg.depth_zero;
    assign res.saturated  = out_reg.saturated;

endmodule

// ----- src/pjc_checker.sv -----
`include "pinhole_project_with_jacobian_core_defines.svh"

module pjc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  res_valid,
    input logic                  res_ready,
    input pjc_pkg::word_t        pixel_u,
    input pjc_pkg::word_t        pixel_v,
    input pjc_pkg::word_t        du_by_dx,
    input pjc_pkg::word_t        du_by_dy,
    input pjc_pkg::word_t        du_by_dz,
    input pjc_pkg::word_t        dv_by_dy,
    input pjc_pkg::word_t        dv_by_dz,
    input logic                  depth_zero,
    input logic                  saturated
);
    import pjc_pkg::*;

    logic pix_zero;
    logic jac_zero;

    // value fields of a zero-depth result
    assign pix_zero = pixel_u == '0 && pixel_v == '0 && !saturated;
    assign jac_zero = du_by_dx == '0 && du_by_dy == '0 && du_by_dz == '0
                   && dv_by_dy == '0 && dv_by_dz == '0;

    // no result after an edge in reset
    `PJC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !res_valid)

    // a stalled result stays offered
    `PJC_ASSERT_RST(a_hold, rst_n, res_valid && !res_ready |=> res_valid)

    // zero depth gives zero pixel values and no clipping
    `PJC_ASSERT_RST(a_zero_pix, rst_n, res_valid && depth_zero |-> pix_zero)

    // zero depth gives zero jacobian
    `PJC_ASSERT_RST(a_zero_jac, rst_n, res_valid && depth_zero |-> jac_zero)

endmodule

bind pinhole_project_with_jacobian_core pjc_checker u_pjc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .pixel_u    (res.pixel_u),
    .pixel_v    (res.pixel_v),
    .du_by_dx   (res.du_by_dx),
    .du_by_dy   (res.du_by_dy),
    .du_by_dz   (res.du_by_dz),
    .dv_by_dy   (res.dv_by_dy),
    .dv_by_dz   (res.dv_by_dz),
    .depth_zero (res.depth_zero),
    .saturated  (res.saturated)
);
